@@ src/hbeg_pkg.sv @@
// ----------------------------------------------------------------------------
// hbeg_pkg
// Shared widths, constants, types and state codes of the heart-beat event
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbeg_pkg;

  // Defaults of the top-level parameters.
  localparam int TICK_CYCLES_DEF = 8192;
  localparam int CLOCK_FREQ_DEF  = 32768;

  // Field widths.
  localparam int RATE_W    = 8;
  localparam int TIME_W    = 16;
  localparam int COUNT_W   = 8;
  localparam int BEATS_W   = 9;
  localparam int ELAPSED_W = 17;

  // Divider operand widths: a 17-bit dividend and a 16-bit divisor.
  localparam int DIVIDEND_W = ELAPSED_W;
  localparam int DIVISOR_W  = TIME_W;

  // Beat quotient width: 131071 / 240 stays below 1024.
  localparam int QUOT_W = 10;

  // Time units (1/1024 s) per minute.
  localparam logic [DIVIDEND_W-1:0] UNITS_PER_MINUTE = DIVIDEND_W'(60 * 1024);
  localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX      = '1;
  localparam logic [BEATS_W-1:0]    BEATS_FIELD_MAX  = '1;
  localparam logic [RATE_W-1:0]     START_RATE_RESET = RATE_W'(60);

  // Input kinds carried in the slave tuser bit.
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SET_RATE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAP,
    ST_DIVI,
    ST_DIVB,
    ST_ADV,
    ST_PREV,
    ST_HOLD
  } state_t;

  // One result item, handed from the core to the output register.
  typedef struct packed {
    logic                rate_error;
    logic [BEATS_W-1:0]  beats_added;
    logic [COUNT_W-1:0]  beat_count;
    logic [TIME_W-1:0]   prev_beat_time;
    logic [TIME_W-1:0]   beat_time;
    logic [RATE_W-1:0]   shown_rate;
  } result_t;

endpackage

`default_nettype wire

@@ src/hbeg_div.sv @@
// ----------------------------------------------------------------------------
// hbeg_div
// Restoring radix-2 divider: one quotient bit per cycle, quotient and
// remainder valid when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module hbeg_div #(
  parameter int N = hbeg_pkg::DIVIDEND_W,
  parameter int D = hbeg_pkg::DIVISOR_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quotient,
  output logic [D-1:0]      remainder
);

  localparam int CNT_W = $clog2(N + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     dsr;
  logic [D:0]       rem_sh;
  logic [D:0]       rem_diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh   = {remainder, quotient[N-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    fits     = rem_sh >= {1'b0, dsr};
  end

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= fits ? rem_diff[D-1:0] : rem_sh[D-1:0];
      quotient  <= {quotient[N-2:0], fits};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/hbeg_core.sv @@
// ----------------------------------------------------------------------------
// hbeg_core
// Measurement state and sequencer: advances elapsed time per tick, derives
// the beat interval and the due beats with the shared serial divider and
// updates the beat event fields.
// ----------------------------------------------------------------------------
`default_nettype none

module hbeg_core #(
  parameter int TICK_CYCLES = hbeg_pkg::TICK_CYCLES_DEF,
  parameter int CLOCK_FREQ  = hbeg_pkg::CLOCK_FREQ_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [hbeg_pkg::RATE_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_cmd,
  input  wire logic [hbeg_pkg::RATE_W-1:0] in_rate,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output hbeg_pkg::result_t                res
);

  localparam int RATE_W    = hbeg_pkg::RATE_W;
  localparam int TIME_W    = hbeg_pkg::TIME_W;
  localparam int COUNT_W   = hbeg_pkg::COUNT_W;
  localparam int BEATS_W   = hbeg_pkg::BEATS_W;
  localparam int ELAPSED_W = hbeg_pkg::ELAPSED_W;
  localparam int DVD_W     = hbeg_pkg::DIVIDEND_W;
  localparam int DVS_W     = hbeg_pkg::DIVISOR_W;
  localparam int QUOT_W    = hbeg_pkg::QUOT_W;
  localparam int SUM_W     = ELAPSED_W + 1;

  // Whole and fractional time units of one tick.
  localparam int WHOLE  = (TICK_CYCLES * 1024) / CLOCK_FREQ;
  localparam int PART   = (TICK_CYCLES * 1024) % CLOCK_FREQ;
  localparam int FRAC_W = $clog2(CLOCK_FREQ);

  hbeg_pkg::state_t state, state_next;

  logic [RATE_W-1:0]    current_rate;
  logic [ELAPSED_W-1:0] elapsed;
  logic [FRAC_W-1:0]    fraction;
  logic                 frac_carry;
  logic [TIME_W-1:0]    last_beat_time;
  logic [TIME_W-1:0]    prev_beat_store;
  logic [COUNT_W-1:0]   beat_counter;
  logic [RATE_W-1:0]    latched_rate;
  logic [TIME_W-1:0]    interval;
  logic [ELAPSED_W-1:0] advance;
  logic [BEATS_W-1:0]   beats_out;
  logic                 err_out;

  logic [FRAC_W:0]      frac_sum;
  logic                 frac_over;
  logic [SUM_W-1:0]     elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic [QUOT_W-1:0]    beats;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DVD_W-1:0]     div_quo;
  logic [DVS_W-1:0]     div_rem;

  hbeg_div #(
    .N(DVD_W),
    .D(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Fraction carry, elapsed-time advance with saturation, beat quotient.
  always_comb begin
    frac_sum    = {1'b0, fraction} + (FRAC_W + 1)'(PART);
    frac_over   = frac_sum >= (FRAC_W + 1)'(CLOCK_FREQ);
    elapsed_sum = {1'b0, elapsed} + SUM_W'(WHOLE) + SUM_W'(frac_carry);
    elapsed_sat = (elapsed_sum > {1'b0, hbeg_pkg::ELAPSED_MAX}) ?
                  hbeg_pkg::ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
    beats       = div_quo[QUOT_W-1:0];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbeg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider control.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = hbeg_pkg::UNITS_PER_MINUTE;
    div_divisor  = DVS_W'(current_rate);
    in_ready     = (state == hbeg_pkg::ST_IDLE);
    res_valid    = (state == hbeg_pkg::ST_HOLD);
    case (state)
      hbeg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_cmd == hbeg_pkg::CMD_SET_RATE) ?
                       hbeg_pkg::ST_HOLD : hbeg_pkg::ST_ELAP;
        end
      end
      hbeg_pkg::ST_ELAP: begin
        if (current_rate == '0) begin
          state_next = hbeg_pkg::ST_HOLD;
        end else begin
          div_start  = 1'b1;
          state_next = hbeg_pkg::ST_DIVI;
        end
      end
      hbeg_pkg::ST_DIVI: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = elapsed;
          div_divisor  = div_quo[DVS_W-1:0];
          state_next   = hbeg_pkg::ST_DIVB;
        end
      end
      hbeg_pkg::ST_DIVB: begin
        if (div_done) begin
          state_next = (beats != '0) ? hbeg_pkg::ST_ADV : hbeg_pkg::ST_HOLD;
        end
      end
      hbeg_pkg::ST_ADV: begin
        state_next = hbeg_pkg::ST_PREV;
      end
      hbeg_pkg::ST_PREV: begin
        state_next = hbeg_pkg::ST_HOLD;
      end
      hbeg_pkg::ST_HOLD: begin
        if (res_take) begin
          state_next = hbeg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hbeg_pkg::ST_IDLE;
      end
    endcase
  end

  // Measurement and beat event state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_rate    <= hbeg_pkg::START_RATE_RESET;
      elapsed         <= '0;
      fraction        <= '0;
      frac_carry      <= 1'b0;
      last_beat_time  <= '0;
      prev_beat_store <= '0;
      beat_counter    <= '0;
      latched_rate    <= '0;
      beats_out       <= '0;
      err_out         <= 1'b0;
    end else begin
      case (state)
        hbeg_pkg::ST_IDLE: begin
          if (cfg_we) begin
            current_rate <= cfg_wdata;
            elapsed      <= '0;
            fraction     <= '0;
          end else if (in_valid) begin
            beats_out <= '0;
            if (in_cmd == hbeg_pkg::CMD_SET_RATE) begin
              current_rate <= in_rate;
              err_out      <= (in_rate == '0);
            end else begin
              frac_carry <= frac_over;
              fraction   <= frac_over ?
                            FRAC_W'(frac_sum - (FRAC_W + 1)'(CLOCK_FREQ)) :
                            frac_sum[FRAC_W-1:0];
            end
          end
        end
        hbeg_pkg::ST_ELAP: begin
          elapsed <= elapsed_sat;
          err_out <= (current_rate == '0);
        end
        hbeg_pkg::ST_DIVB: begin
          if (div_done) begin
            beats_out <= (beats > QUOT_W'(hbeg_pkg::BEATS_FIELD_MAX)) ?
                         hbeg_pkg::BEATS_FIELD_MAX : beats[BEATS_W-1:0];
            if (beats != '0) begin
              latched_rate <= current_rate;
              beat_counter <= beat_counter + beats[COUNT_W-1:0];
              advance      <= elapsed - ELAPSED_W'(div_rem);
              elapsed      <= ELAPSED_W'(div_rem);
            end
          end
        end
        hbeg_pkg::ST_ADV: begin
          last_beat_time <= last_beat_time + advance[TIME_W-1:0];
        end
        hbeg_pkg::ST_PREV: begin
          prev_beat_store <= last_beat_time - interval;
        end
        default: begin
        end
      endcase
    end
  end

  // Beat interval, kept for the previous-beat time.
  always_ff @(posedge clk) begin
    if (state == hbeg_pkg::ST_DIVI && div_done) begin
      interval <= div_quo[TIME_W-1:0];
    end
  end

  // Result item.
  always_comb begin
    res.rate_error     = err_out;
    res.beats_added    = beats_out;
    res.beat_count     = beat_counter;
    res.prev_beat_time = prev_beat_store;
    res.beat_time      = last_beat_time;
    res.shown_rate     = latched_rate;
  end

endmodule

`default_nettype wire

@@ src/heart_beat_event_generator_unit.sv @@
// ----------------------------------------------------------------------------
// heart_beat_event_generator_unit
// Turns a heart rate in beats per minute into heart-beat event data, one
// result per tick or set-rate item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                    Contents
//  s_*       in         tvalid/tready/tdata/tuser  new_rate; tuser = cmd
//  m_*       out        tvalid/tready/tdata/tuser  beat event; tuser = rate_error
//  cfg_*     in         we/wdata                   start_rate
//
//  A tick passes from transfer to result through the elapsed-time update,
//  then, for a nonzero rate, two 17-step passes of the serial divider (beat
//  interval, then due beats) and, if beats fall due, the update states ADV
//  and PREV. A set-rate item goes straight to the result.
//  Reset (rst, synchronous) restores start_rate 60 and clears all beat state.
//  A finished result waits in the output register; the next item is taken
//  meanwhile, and its own result waits until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_beat_event_generator_unit #(
  parameter int TICK_CYCLES = hbeg_pkg::TICK_CYCLES_DEF,
  parameter int CLOCK_FREQ  = hbeg_pkg::CLOCK_FREQ_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,   // start_rate
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // [7:0] new_rate
  input  wire logic        s_tuser,     // [0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,     // [7:0] shown_rate, [23:8] beat_time,
                                        // [39:24] prev_beat_time,
                                        // [47:40] beat_count,
                                        // [56:48] beats_added, [63:57] zero
  output logic             m_tuser      // [0] rate_error
);

  hbeg_pkg::result_t res;
  hbeg_pkg::result_t out_res;
  logic              res_valid;
  logic              res_take;

  hbeg_core #(
    .TICK_CYCLES(TICK_CYCLES),
    .CLOCK_FREQ (CLOCK_FREQ)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_rate  (s_tdata),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // The output register loads when it is empty or being emptied.
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= res_take || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  // Pack the result fields onto the stream.
  assign m_tdata = {7'd0, out_res.beats_added, out_res.beat_count,
                    out_res.prev_beat_time, out_res.beat_time,
                    out_res.shown_rate};
  assign m_tuser = out_res.rate_error;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heart_beat_event_generator_unit. Set-rate and tick
// items are streamed in with random gaps while the result side stalls at
// random. A local beat-event model predicts every result at the moment its
// item transfers, and the monitor compares each result, field by field, with
// the oldest prediction. Between phases the start_rate register is rewritten,
// extremes included, once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATE_W  = hbeg_pkg::RATE_W;
  localparam int TIME_W  = hbeg_pkg::TIME_W;
  localparam int COUNT_W = hbeg_pkg::COUNT_W;
  localparam int BEATS_W = hbeg_pkg::BEATS_W;

  // One input item as the bench sees it.
  typedef struct packed {
    logic             cmd;
    logic [RATE_W-1:0] rate;
  } hr_item_t;

  // Time units added per tick and the source-clock remainder carried.
  localparam int unsigned TICK_UNITS =
    (hbeg_pkg::TICK_CYCLES_DEF * 1024) / hbeg_pkg::CLOCK_FREQ_DEF;
  localparam int unsigned TICK_FRAC  =
    (hbeg_pkg::TICK_CYCLES_DEF * 1024) % hbeg_pkg::CLOCK_FREQ_DEF;
  localparam int unsigned MAX_REPORTS = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;     // [7:0] new_rate
  logic              s_tuser = 1'b0;   // [0] cmd
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;          // [7:0] shown_rate, [23:8] beat_time,
                                       // [39:24] prev_beat_time, [47:40] beat_count,
                                       // [56:48] beats_added, [63:57] zero
  logic              m_tuser;          // [0] rate_error

  // Stimulus and expectation stores.
  hr_item_t          pending_items[$];
  hbeg_pkg::result_t beat_events_due[$];
  int unsigned       items_queued = 0;
  int unsigned       items_taken = 0;
  bit                s_took = 1'b0;
  bit                calm = 1'b0;
  bit                mismatch_seen = 1'b0;
  int unsigned       reports = 0;
  int                gap_left = 0;
  int                ready_left = 0;

  // Beat-event model state.
  logic [RATE_W-1:0] mdl_rate;
  int unsigned       mdl_elapsed;
  int unsigned       mdl_frac;
  logic [TIME_W-1:0] mdl_last;
  logic [TIME_W-1:0] mdl_prev;
  logic [COUNT_W-1:0] mdl_count;
  logic [RATE_W-1:0] mdl_shown;

  heart_beat_event_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advances the beat-event model by one item and queues its result.
  task automatic predict_beat_event(input logic cmd, input logic [RATE_W-1:0] rate);
    hbeg_pkg::result_t ev;
    int unsigned interval;
    int unsigned beats;
    beats = 0;
    if (cmd == hbeg_pkg::CMD_SET_RATE) begin
      mdl_rate = rate;
    end else begin
      mdl_elapsed += TICK_UNITS;
      mdl_frac += TICK_FRAC;
      if (mdl_frac >= hbeg_pkg::CLOCK_FREQ_DEF) begin
        mdl_elapsed += 1;
        mdl_frac = mdl_frac % hbeg_pkg::CLOCK_FREQ_DEF;
      end
      if (mdl_elapsed > int'(hbeg_pkg::ELAPSED_MAX)) begin
        mdl_elapsed = int'(hbeg_pkg::ELAPSED_MAX);
      end
      // A zero rate has no interval, so no beat can fall due.
      if (mdl_rate != '0) begin
        interval = int'(hbeg_pkg::UNITS_PER_MINUTE) / int'(mdl_rate);
        beats = mdl_elapsed / interval;
        if (beats > 0) begin
          mdl_shown = mdl_rate;
          mdl_last = mdl_last + TIME_W'(beats * interval);
          mdl_prev = mdl_last - TIME_W'(interval);
          mdl_count = mdl_count + COUNT_W'(beats);
          mdl_elapsed -= beats * interval;
        end
      end
    end
    ev.shown_rate = mdl_shown;
    ev.beat_time = mdl_last;
    ev.prev_beat_time = mdl_prev;
    ev.beat_count = mdl_count;
    ev.beats_added = (beats > int'(hbeg_pkg::BEATS_FIELD_MAX)) ?
                     hbeg_pkg::BEATS_FIELD_MAX : BEATS_W'(beats);
    ev.rate_error = (mdl_rate == '0);
    beat_events_due.push_back(ev);
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_seen = 1'b1;
      if (reports < MAX_REPORTS) begin
        $display("%0t ns: %s expected %0d, actual %0d", $realtime, name, want, got);
        reports++;
      end
    end
  endtask

  // Input transfers feed the model; output transfers are checked.
  always @(posedge clk) begin
    hbeg_pkg::result_t want;
    hbeg_pkg::result_t got;
    s_took = 1'b0;
    if (rst) begin
      mdl_rate = hbeg_pkg::START_RATE_RESET;
      mdl_elapsed = 0;
      mdl_frac = 0;
      mdl_last = '0;
      mdl_prev = '0;
      mdl_count = '0;
      mdl_shown = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (beat_events_due.size() == 0) begin
          mismatch_seen = 1'b1;
          $display("%0t ns: result with none expected, actual tdata %h tuser %b",
                   $realtime, m_tdata, m_tuser);
        end else begin
          want = beat_events_due.pop_front();
          got = hbeg_pkg::result_t'({m_tuser, m_tdata[56:0]});
          check_field("shown_rate", want.shown_rate, got.shown_rate);
          check_field("beat_time", want.beat_time, got.beat_time);
          check_field("prev_beat_time", want.prev_beat_time, got.prev_beat_time);
          check_field("beat_count", want.beat_count, got.beat_count);
          check_field("beats_added", want.beats_added, got.beats_added);
          check_field("rate_error", want.rate_error, got.rate_error);
          check_field("tdata padding", 0, m_tdata[63:57]);
        end
      end
      if (s_tvalid && s_tready) begin
        s_took = 1'b1;
        items_taken++;
        predict_beat_event(s_tuser, s_tdata);
      end
    end
  end

  // Input driver: holds an item until it transfers, then idles for a gap.
  always @(negedge clk) begin
    hr_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_took) begin
      // The current item has not transferred yet.
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      item = pending_items.pop_front();
      s_tdata <= item.rate;
      s_tuser <= item.cmd;
      s_tvalid <= 1'b1;
      gap_left = calm ? 0 : pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result-side back-pressure: runs of ready and stall of random length.
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      m_tready <= calm || ($urandom_range(0, 3) != 0);
      ready_left = calm ? 0 : pick_gap();
    end
  end

  // Queues one item for the driver.
  task automatic queue_item(input logic cmd, input logic [RATE_W-1:0] rate);
    hr_item_t item;
    item.cmd = cmd;
    item.rate = rate;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // Random item: mostly ticks, set-rate values biased toward the extremes.
  task automatic queue_random_item();
    int pick;
    if ($urandom_range(0, 99) < 15) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: queue_item(hbeg_pkg::CMD_SET_RATE, 8'd0);
        1: queue_item(hbeg_pkg::CMD_SET_RATE, 8'd255);
        2: queue_item(hbeg_pkg::CMD_SET_RATE, 8'd1);
        default: queue_item(hbeg_pkg::CMD_SET_RATE, RATE_W'($urandom_range(0, 255)));
      endcase
    end else begin
      queue_item(hbeg_pkg::CMD_TICK, RATE_W'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every queued item has transferred and every result arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || beat_events_due.size() != 0);
  endtask

  // Writes start_rate while the block is idle and mirrors it in the model.
  task automatic program_start_rate(input logic [RATE_W-1:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    mdl_rate = value;
    mdl_elapsed = 0;
    mdl_frac = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Run limit.
  initial begin
    #25_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    logic [RATE_W-1:0] phase_rate[5];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset rate: beats, zero rate, extremes of new_rate.
    repeat (4) queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_TICK, 8'hFF);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd0);
    repeat (2) queue_item(hbeg_pkg::CMD_TICK, 8'hA5);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd255);
    queue_item(hbeg_pkg::CMD_TICK, 8'h5A);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd1);
    repeat (2) queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'hAA);
    queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'h55);
    queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd240);
    queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd128);
    repeat (2) queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd60);
    repeat (3) queue_item(hbeg_pkg::CMD_TICK, 8'h00);
    wait_drained();

    // Zero start rate: the elapsed time saturates, then a fast rate makes more
    // beats fall due at once than the beats_added field can show.
    program_start_rate(8'd0);
    repeat (520) queue_item(hbeg_pkg::CMD_TICK, RATE_W'($urandom_range(0, 255)));
    queue_item(hbeg_pkg::CMD_SET_RATE, 8'd255);
    repeat (3) queue_item(hbeg_pkg::CMD_TICK, RATE_W'($urandom_range(0, 255)));
    wait_drained();

    // Random phases under several start rates; one runs without idling.
    phase_rate[0] = 8'd255;
    phase_rate[1] = 8'd1;
    phase_rate[2] = RATE_W'($urandom_range(2, 254));
    phase_rate[3] = 8'd60;
    phase_rate[4] = RATE_W'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      program_start_rate(phase_rate[p]);
      calm = (p == 2);
      repeat (160) queue_random_item();
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (!mismatch_seen && beat_events_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/hbeg_pkg.sv
src/hbeg_div.sv
src/hbeg_core.sv
src/heart_beat_event_generator_unit.sv
test/testbench.sv
